// ===== rtl/core/fds_pkg.sv =====
// Shared types, constants and command/status structs of the frame interval smoother.
`default_nettype none
package fds_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int DELTA_W      = 24;
  localparam int AW           = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W        = DELTA_W + AW;
  localparam int LEFT_W       = 7;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_MITIGATION  = 3'd1,
    REG_PASSTHROUGH = 3'd2,
    REG_TARGET      = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_PASS     = 2'd1,
    MODE_MITIGATE = 2'd2,
    MODE_ABSORB   = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_FILL, S_HEAD_RD, S_HEAD_WR,
    S_FL_RD, S_FL_ACC, S_FL_WR,
    S_AB_RDN, S_AB_NEW, S_AB_OLD, S_AB_SRD, S_AB_SCHK, S_AB_DIVST, S_AB_DIV,
    S_AB_WR, S_AB_NEXT, S_OUT
  } state_t;

  typedef enum logic [1:0] {ADDR_HEAD, ADDR_K, ADDR_POS, ADDR_POS1} addr_sel_t;
  typedef enum logic [2:0] {WD_ZERO, WD_TARGET, WD_RAW, WD_MEAN, WD_FLAT} wdata_sel_t;
  typedef enum logic [2:0] {K_HOLD, K_CLR, K_INC, K_POS, K_POS1} k_op_t;
  typedef enum logic [1:0] {POS_HOLD, POS_INIT, POS_DEC} pos_op_t;
  typedef enum logic [1:0] {LEFT_HOLD, LEFT_CLEAR, LEFT_STEP} left_op_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_ADD, ACC_OLDER} acc_op_t;

  typedef struct packed {
    logic       raw_ld;
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    k_op_t      k_op;
    pos_op_t    pos_op;
    left_op_t   left_op;
    acc_op_t    acc_op;
    logic       newer_ld;
    logic       head_inc;
    logic       res_ld;
    logic       filled_set;
    logic       mode_ld;
    mode_t      mode;
    logic       div_start;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic pass_hit;
    logic mitig;
    logic filled;
    logic k_last;
    logic k_at_end;
    logic pos_zero;
    logic older_gt;
    logic le_newer;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/frame_delta_smoother.sv =====
// Top level of the frame interval smoother: controller, datapath and ports.
// Each request carries one measured frame interval (us) and yields one result:
// the interval to use and the mode. The work depends on the path: a disabled
// request goes straight to the output; a passthrough or a smoothing request with
// full-buffer averaging reads and sums the buffer, then writes back the shifted
// mean; absorption walks the delay buffer through one memory read port with a
// bit-serial divider run for each averaged run of entries, so it takes longer the
// more positions start a run. The first smoothing request adds a fill of the
// buffer with the target interval. After reset a clearing pass runs before the
// first request is taken; register writes are taken at any time.
`default_nettype none
module frame_delta_smoother
  import fds_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [DELTA_W-1:0]   in_raw_delta,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [DELTA_W-1:0]   out_smoothed_delta,
  output logic      [1:0]           out_mode,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DELTA_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fds_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_raw_delta       (in_raw_delta),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_smoothed_delta (out_smoothed_delta),
    .out_mode           (out_mode)
  );

endmodule
`default_nettype wire

// ===== rtl/core/fds_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fds_div
  import fds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [CNT_W-1:0]   divisor,
  output logic      [DELTA_W-1:0] quotient,
  output logic                    done
);

  localparam int DCW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] num_r, num_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dvs_r;
  logic [DCW-1:0]   cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;

  always_comb begin
    trial    = {rem_r, num_r[SUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DCW'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[CNT_W-1:0];
        num_nxt = {num_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        num_nxt = {num_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DCW'(1);
      if (cnt_r == DCW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = num_r[DELTA_W-1:0];
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/fds_datapath.sv =====
// Datapath: registers, delay buffer memory, accumulator, divider and output register.
`default_nettype none
module fds_datapath
  import fds_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [DELTA_W-1:0]   in_raw_delta,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DELTA_W-1:0]   cfg_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic      [DELTA_W-1:0]   out_smoothed_delta,
  output logic      [1:0]           out_mode
);

  logic               enable_r;
  logic [DELTA_W-1:0] mit_thr_r, pass_thr_r, target_r;
  logic [DELTA_W-1:0] mem [BUFFER_DEPTH];
  logic [DELTA_W-1:0] rdata_r;
  logic [AW-1:0]      head_r, k_r, pos_r;
  logic [AW-1:0]      k_nxt, pos_nxt, lg, addr;
  logic [CNT_W-1:0]   run_r;
  logic [SUM_W-1:0]   total_r;
  logic [DELTA_W-1:0] newer_r, raw_r, res_r, wdata;
  mode_t              mode_r;
  logic               filled_r;
  logic [LEFT_W-1:0]  left_r, left_eff;
  logic               out_valid_r;
  logic [DELTA_W-1:0] out_delta_r;
  logic [1:0]         out_mode_r;
  logic               pass_hit, mit_hit;
  logic [DELTA_W-1:0] mean;
  logic               div_done;
  logic [CNT_W:0]     end_pos;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(BUFFER_DEPTH)) begin
      s = s - (AW+1)'(BUFFER_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  fds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (total_r),
    .divisor  (run_r),
    .quotient (mean),
    .done     (div_done)
  );

  always_comb begin
    case (cmd.addr_sel)
      ADDR_HEAD: lg = '0;
      ADDR_K:    lg = k_r;
      ADDR_POS:  lg = pos_r;
      ADDR_POS1: lg = pos_r + AW'(1);
      default:   lg = '0;
    endcase
    addr = wrap_add(head_r, lg);
    case (cmd.wdata_sel)
      WD_ZERO:   wdata = '0;
      WD_TARGET: wdata = target_r;
      WD_RAW:    wdata = raw_r;
      WD_MEAN:   wdata = mean;
      WD_FLAT:   wdata = total_r[AW +: DELTA_W];
      default:   wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_comb begin
    case (cmd.k_op)
      K_CLR:   k_nxt = '0;
      K_INC:   k_nxt = k_r + AW'(1);
      K_POS:   k_nxt = pos_r;
      K_POS1:  k_nxt = pos_r + AW'(1);
      default: k_nxt = k_r;
    endcase
    case (cmd.pos_op)
      POS_INIT: pos_nxt = AW'(BUFFER_DEPTH - 2);
      POS_DEC:  pos_nxt = pos_r - AW'(1);
      default:  pos_nxt = pos_r;
    endcase
  end

  assign pass_hit = (pass_thr_r != '0) && (raw_r >= pass_thr_r);
  assign mit_hit  = (mit_thr_r != '0) && (raw_r >= mit_thr_r);
  assign left_eff = mit_hit ? LEFT_W'(BUFFER_DEPTH) : left_r;
  assign end_pos  = {1'b0, CNT_W'(pos_r)} + {1'b0, run_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      mit_thr_r   <= DELTA_W'(70000);
      pass_thr_r  <= DELTA_W'(100000);
      target_r    <= DELTA_W'(16667);
      head_r      <= '0;
      k_r         <= '0;
      pos_r       <= '0;
      filled_r    <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLE:      enable_r   <= cfg_data[0];
          REG_MITIGATION:  mit_thr_r  <= cfg_data;
          REG_PASSTHROUGH: pass_thr_r <= cfg_data;
          REG_TARGET:      target_r   <= cfg_data;
          default: ;
        endcase
      end
      k_r   <= k_nxt;
      pos_r <= pos_nxt;
      if (cmd.head_inc) begin
        head_r <= wrap_add(head_r, AW'(1));
      end
      if (cmd.filled_set) begin
        filled_r <= 1'b1;
      end
      case (cmd.left_op)
        LEFT_CLEAR: left_r <= '0;
        LEFT_STEP:  left_r <= (left_eff != '0) ? left_eff - LEFT_W'(1) : '0;
        default: ;
      endcase
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.raw_ld) begin
      raw_r <= in_raw_delta;
    end
    if (cmd.newer_ld) begin
      newer_r <= rdata_r;
    end
    if (cmd.res_ld) begin
      res_r <= rdata_r;
    end
    if (cmd.mode_ld) begin
      mode_r <= cmd.mode;
    end
    case (cmd.acc_op)
      ACC_CLR: begin
        total_r <= '0;
        run_r   <= '0;
      end
      ACC_ADD: begin
        total_r <= total_r + SUM_W'(rdata_r);
        run_r   <= run_r + CNT_W'(1);
      end
      ACC_OLDER: begin
        total_r <= SUM_W'(rdata_r);
        run_r   <= CNT_W'(1);
      end
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_delta_r <= (mode_r == MODE_DISABLED || mode_r == MODE_PASS) ? raw_r : res_r;
      out_mode_r  <= mode_r;
    end
  end

  always_comb begin
    sts.enable   = enable_r;
    sts.pass_hit = pass_hit;
    sts.mitig    = mit_hit || (left_r != '0);
    sts.filled   = filled_r;
    sts.k_last   = (k_r == AW'(BUFFER_DEPTH - 1));
    sts.k_at_end = ({1'b0, CNT_W'(k_r)} + (CNT_W+1)'(1)) == end_pos;
    sts.pos_zero = (pos_r == '0);
    sts.older_gt = rdata_r > newer_r;
    sts.le_newer = rdata_r <= newer_r;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_delta = out_delta_r;
  assign out_mode           = out_mode_r;

endmodule
`default_nettype wire

// ===== rtl/core/fds_ctrl.sv =====
// Controller state machine sequencing buffer clear, fill, shift, flatten and absorb walks.
`default_nettype none
module fds_ctrl
  import fds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (sts.k_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!sts.enable) state_nxt = S_OUT;
        else if (sts.pass_hit) state_nxt = S_FL_RD;
        else if (!sts.filled) state_nxt = S_FILL;
        else state_nxt = S_HEAD_RD;
      end
      S_FILL:     if (sts.k_last) state_nxt = S_HEAD_RD;
      S_HEAD_RD:  state_nxt = S_HEAD_WR;
      S_HEAD_WR:  state_nxt = sts.mitig ? S_FL_RD : S_AB_RDN;
      S_FL_RD:    state_nxt = S_FL_ACC;
      S_FL_ACC:   state_nxt = sts.k_last ? S_FL_WR : S_FL_RD;
      S_FL_WR:    if (sts.k_last) state_nxt = S_OUT;
      S_AB_RDN:   state_nxt = S_AB_NEW;
      S_AB_NEW:   state_nxt = S_AB_OLD;
      S_AB_OLD:   state_nxt = sts.older_gt ? S_AB_SRD : S_AB_NEXT;
      S_AB_SRD:   state_nxt = S_AB_SCHK;
      S_AB_SCHK: begin
        if (!sts.le_newer || sts.k_last) state_nxt = S_AB_DIVST;
        else state_nxt = S_AB_SRD;
      end
      S_AB_DIVST: state_nxt = S_AB_DIV;
      S_AB_DIV:   if (sts.div_done) state_nxt = S_AB_WR;
      S_AB_WR:    if (sts.k_at_end) state_nxt = S_AB_NEXT;
      S_AB_NEXT:  state_nxt = sts.pos_zero ? S_OUT : S_AB_RDN;
      S_OUT:      if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.addr_sel  = ADDR_K;
    cmd.wdata_sel = WD_ZERO;
    cmd.k_op      = K_HOLD;
    cmd.pos_op    = POS_HOLD;
    cmd.left_op   = LEFT_HOLD;
    cmd.acc_op    = ACC_HOLD;
    cmd.mode      = MODE_DISABLED;
    in_stall      = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.mem_wr = 1'b1;
        cmd.k_op   = sts.k_last ? K_CLR : K_INC;
      end
      S_IDLE: begin
        cmd.raw_ld = in_valid;
      end
      S_DECIDE: begin
        cmd.k_op   = K_CLR;
        cmd.acc_op = ACC_CLR;
        if (!sts.enable) begin
          cmd.mode_ld = 1'b1;
          cmd.mode    = MODE_DISABLED;
        end else if (sts.pass_hit) begin
          cmd.mode_ld = 1'b1;
          cmd.mode    = MODE_PASS;
          cmd.left_op = LEFT_CLEAR;
        end
      end
      S_FILL: begin
        cmd.mem_wr     = 1'b1;
        cmd.wdata_sel  = WD_TARGET;
        cmd.k_op       = K_INC;
        cmd.filled_set = sts.k_last;
      end
      S_HEAD_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_HEAD;
      end
      S_HEAD_WR: begin
        cmd.res_ld    = 1'b1;
        cmd.mem_wr    = 1'b1;
        cmd.addr_sel  = ADDR_HEAD;
        cmd.wdata_sel = WD_RAW;
        cmd.head_inc  = 1'b1;
        cmd.left_op   = LEFT_STEP;
        cmd.mode_ld   = 1'b1;
        cmd.k_op      = K_CLR;
        cmd.acc_op    = ACC_CLR;
        cmd.pos_op    = POS_INIT;
        cmd.mode      = sts.mitig ? MODE_MITIGATE : MODE_ABSORB;
      end
      S_FL_RD: begin
        cmd.mem_rd = 1'b1;
      end
      S_FL_ACC: begin
        cmd.acc_op = ACC_ADD;
        cmd.k_op   = K_INC;
      end
      S_FL_WR: begin
        cmd.mem_wr    = 1'b1;
        cmd.wdata_sel = WD_FLAT;
        cmd.k_op      = K_INC;
      end
      S_AB_RDN: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_POS1;
      end
      S_AB_NEW: begin
        cmd.newer_ld = 1'b1;
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_POS;
      end
      S_AB_OLD: begin
        if (sts.older_gt) begin
          cmd.acc_op = ACC_OLDER;
          cmd.k_op   = K_POS1;
        end
      end
      S_AB_SRD: begin
        cmd.mem_rd = 1'b1;
      end
      S_AB_SCHK: begin
        if (sts.le_newer) begin
          cmd.acc_op = ACC_ADD;
          cmd.k_op   = K_INC;
        end
      end
      S_AB_DIVST: begin
        cmd.div_start = 1'b1;
        cmd.k_op      = K_POS;
      end
      S_AB_WR: begin
        cmd.mem_wr    = 1'b1;
        cmd.wdata_sel = WD_MEAN;
        cmd.k_op      = K_INC;
      end
      S_AB_NEXT: begin
        cmd.pos_op = sts.pos_zero ? POS_HOLD : POS_DEC;
      end
      S_OUT: begin
        cmd.out_ld = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
